FILE: hdl/lmsd_pkg.sv
// ---------------------------------------------------------------------------
// lmsd_pkg
// Shared types, constants and helpers for the LED matrix scan driver.
// ---------------------------------------------------------------------------
package lmsd_pkg;

    // Panel geometry
    localparam int DOUBLE_ROWS = 16;
    localparam int COLUMNS     = 32;
    localparam int PLANES      = 2;

    localparam int STORE_DEPTH = PLANES * DOUBLE_ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_CNT_W   = $clog2(DOUBLE_ROWS);
    localparam int COL_CNT_W   = $clog2(COLUMNS);

    // Field widths
    localparam int COLOR_W    = 6;
    localparam int ROW_FLD_W  = 4;
    localparam int COL_FLD_W  = 5;
    localparam int IDLE_W     = 16;
    localparam int PHASE_W    = 3;

    localparam logic [IDLE_W-1:0] IDLE_TICKS_RESET = 16'd1792;

    // Item kinds
    localparam logic KIND_PIXEL_WRITE = 1'b0;
    localparam logic KIND_SCAN_TICK   = 1'b1;

    // Phases within one column / row tail
    localparam logic [PHASE_W-1:0] PH_CLK_HIGH   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CLK_LOW    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LATCH_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LATCH_LOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ENABLE_ON  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_ENABLE_OFF = 3'd5;

    // Subframe sequencer
    typedef enum logic [3:0] {
        SF_PLANE0_A = 4'b0001,
        SF_PLANE1   = 4'b0010,
        SF_PLANE0_B = 4'b0100,
        SF_IDLE     = 4'b1000
    } subframe_t;

    typedef struct packed {
        logic                 kind;
        logic                 plane;
        logic [ROW_FLD_W-1:0] double_row;
        logic [COL_FLD_W-1:0] column;
        logic [COLOR_W-1:0]   color;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0]   color_pins;
        logic                 shift_clock;
        logic                 latch_pin;
        logic                 blank_n;
        logic [ROW_FLD_W-1:0] row_address;
        logic                 frame_end;
    } res_t;

    // Pin levels of one tick, less the data lines
    typedef struct packed {
        logic                 show_pixel;
        logic                 shift_clock;
        logic                 latch_pin;
        logic                 blank_n;
        logic [ROW_FLD_W-1:0] row_address;
        logic                 frame_end;
    } tick_ctrl_t;

    function automatic logic [ADDR_W-1:0] pixel_index(
        input logic                 plane,
        input logic [ROW_CNT_W-1:0] row,
        input logic [COL_CNT_W-1:0] col
    );
        pixel_index = ADDR_W'((int'(plane) * DOUBLE_ROWS + int'(row)) * COLUMNS
                              + int'(col));
    endfunction

endpackage

FILE: hdl/lmsd_ram.sv
// ---------------------------------------------------------------------------
// lmsd_ram
// Generic simple dual-port RAM with registered read.
// ---------------------------------------------------------------------------
module lmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lmsd_scan_ctrl.sv
// ---------------------------------------------------------------------------
// lmsd_scan_ctrl
// Scan sequencer: subframe, row, column, phase and idle counters. Gives the
// pin levels and pixel address of the current tick and advances on step.
// ---------------------------------------------------------------------------
module lmsd_scan_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [lmsd_pkg::IDLE_W-1:0]       idle_ticks,
    output lmsd_pkg::tick_ctrl_t              ctrl,
    output logic [lmsd_pkg::ADDR_W-1:0]       rd_addr
);

    lmsd_pkg::subframe_t                   sf_reg, sf_next;
    logic [lmsd_pkg::ROW_CNT_W-1:0]        row_reg, row_next;
    logic [lmsd_pkg::COL_CNT_W-1:0]        col_reg, col_next;
    logic [lmsd_pkg::PHASE_W-1:0]          phase_reg, phase_next;
    logic [lmsd_pkg::IDLE_W-1:0]           idle_reg, idle_next;

    logic                                  scanning;
    logic                                  plane;
    logic                                  last_col;
    logic                                  last_row;
    logic                                  row_done;
    logic [lmsd_pkg::IDLE_W:0]             idle_inc;

    always_comb
    begin
        scanning = (sf_reg != lmsd_pkg::SF_IDLE);
        plane    = (sf_reg == lmsd_pkg::SF_PLANE1) && (lmsd_pkg::PLANES > 1);
        last_col = (int'(col_reg) == lmsd_pkg::COLUMNS - 1);
        last_row = (int'(row_reg) == lmsd_pkg::DOUBLE_ROWS - 1);
        row_done = (phase_reg == lmsd_pkg::PH_ENABLE_OFF);
        idle_inc = {1'b0, idle_reg} + 1'b1;

        ctrl.show_pixel  = scanning;
        ctrl.shift_clock = scanning && (phase_reg == lmsd_pkg::PH_CLK_HIGH);
        ctrl.latch_pin   = scanning && (phase_reg == lmsd_pkg::PH_LATCH_HIGH);
        ctrl.blank_n     = !(scanning && (phase_reg == lmsd_pkg::PH_ENABLE_ON));
        ctrl.row_address = scanning ? lmsd_pkg::ROW_FLD_W'(row_reg) : '0;
        ctrl.frame_end   = (sf_reg == lmsd_pkg::SF_PLANE0_B) && row_done && last_row;

        rd_addr = lmsd_pkg::pixel_index(plane, row_reg, col_reg);

        sf_next    = sf_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        idle_next  = idle_reg;

        if (!scanning)
        begin
            // Count idle ticks; restart the frame once the count is reached
            if (idle_inc >= {1'b0, idle_ticks})
            begin
                idle_next  = '0;
                sf_next    = lmsd_pkg::SF_PLANE0_A;
                row_next   = '0;
                col_next   = '0;
                phase_next = lmsd_pkg::PH_CLK_HIGH;
            end
            else
            begin
                idle_next = idle_inc[lmsd_pkg::IDLE_W-1:0];
            end
        end
        else if (phase_reg == lmsd_pkg::PH_CLK_LOW && !last_col)
        begin
            col_next   = col_reg + 1'b1;
            phase_next = lmsd_pkg::PH_CLK_HIGH;
        end
        else if (!row_done)
        begin
            phase_next = phase_reg + 1'b1;
        end
        else
        begin
            phase_next = lmsd_pkg::PH_CLK_HIGH;
            col_next   = '0;
            if (!last_row)
            begin
                row_next = row_reg + 1'b1;
            end
            else
            begin
                row_next = '0;
                case (sf_reg)
                    lmsd_pkg::SF_PLANE0_A: sf_next = lmsd_pkg::SF_PLANE1;
                    lmsd_pkg::SF_PLANE1:   sf_next = lmsd_pkg::SF_PLANE0_B;
                    default:
                    begin
                        idle_next = '0;
                        sf_next   = (idle_ticks == '0) ? lmsd_pkg::SF_PLANE0_A
                                                       : lmsd_pkg::SF_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg    <= lmsd_pkg::SF_PLANE0_A;
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= lmsd_pkg::PH_CLK_HIGH;
            idle_reg  <= '0;
        end
        else if (step)
        begin
            sf_reg    <= sf_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

FILE: hdl/led_matrix_scan_driver_unit.sv
// ---------------------------------------------------------------------------
// led_matrix_scan_driver_unit
// Scan driver for a 32x32 split-row RGB matrix with a two-plane pixel buffer.
// ---------------------------------------------------------------------------
// Each accepted beat is either a pixel write (no result) or a scan tick (one
// result beat of pin levels). One beat is taken every clock while req_stall is
// low; the pixel buffer read for a tick is registered at the accepting edge and
// the result register loads from it once the result side is not stalled.
// After reset the buffer is swept to zero, one entry a cycle, so req_stall
// stays high until all 1024 entries are cleared; the idle_ticks register may be
// written during that time.
// ---------------------------------------------------------------------------
module led_matrix_scan_driver_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  lmsd_pkg::req_t               req,
    output logic                         res_valid,
    input  logic                         res_stall,
    output lmsd_pkg::res_t               res,
    input  logic                         cfg_write_enable,
    input  logic [lmsd_pkg::IDLE_W-1:0]  cfg_write_data
);

    logic [lmsd_pkg::IDLE_W-1:0]  idle_ticks_reg;
    logic                         clr_busy_reg;
    logic [lmsd_pkg::ADDR_W-1:0]  clr_addr_reg;

    logic                         a_valid_reg;
    lmsd_pkg::tick_ctrl_t         a_ctrl_reg;
    logic                         b_valid_reg;
    lmsd_pkg::res_t               b_reg;

    logic                         accept;
    logic                         accept_tick;
    logic                         accept_write;
    logic                         a_advance;
    logic                         wr_in_range;

    logic                         ram_we;
    logic [lmsd_pkg::ADDR_W-1:0]  ram_waddr;
    logic [lmsd_pkg::COLOR_W-1:0] ram_wdata;
    logic [lmsd_pkg::ADDR_W-1:0]  ram_raddr;
    logic [lmsd_pkg::COLOR_W-1:0] ram_rdata;

    lmsd_pkg::tick_ctrl_t         tick_ctrl;

    always_comb
    begin
        a_advance   = a_valid_reg && (!b_valid_reg || !res_stall);
        req_stall   = clr_busy_reg || (a_valid_reg && !a_advance);
        accept      = req_valid && !req_stall;
        accept_tick = accept && (req.kind == lmsd_pkg::KIND_SCAN_TICK);

        // Drop writes that fall outside the buffer
        wr_in_range = (int'(req.plane) < lmsd_pkg::PLANES)
                   && (int'(req.double_row) < lmsd_pkg::DOUBLE_ROWS)
                   && (int'(req.column) < lmsd_pkg::COLUMNS);
        accept_write = accept && (req.kind == lmsd_pkg::KIND_PIXEL_WRITE) && wr_in_range;

        ram_we    = clr_busy_reg || accept_write;
        ram_waddr = clr_busy_reg ? clr_addr_reg
                                 : lmsd_pkg::pixel_index(req.plane,
                                       lmsd_pkg::ROW_CNT_W'(req.double_row),
                                       lmsd_pkg::COL_CNT_W'(req.column));
        ram_wdata = clr_busy_reg ? '0 : req.color;
    end

    lmsd_scan_ctrl u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept_tick),
        .idle_ticks (idle_ticks_reg),
        .ctrl       (tick_ctrl),
        .rd_addr    (ram_raddr)
    );

    lmsd_ram #(
        .WIDTH (lmsd_pkg::COLOR_W),
        .DEPTH (lmsd_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept_tick),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg <= lmsd_pkg::IDLE_TICKS_RESET;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                idle_ticks_reg <= cfg_write_data;
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (int'(clr_addr_reg) == lmsd_pkg::STORE_DEPTH - 1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            a_valid_reg <= accept_tick || (a_valid_reg && !a_advance);
            b_valid_reg <= a_advance || (b_valid_reg && res_stall);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept_tick)
        begin
            a_ctrl_reg <= tick_ctrl;
        end
        if (a_advance)
        begin
            b_reg.color_pins  <= a_ctrl_reg.show_pixel ? ram_rdata : '0;
            b_reg.shift_clock <= a_ctrl_reg.shift_clock;
            b_reg.latch_pin   <= a_ctrl_reg.latch_pin;
            b_reg.blank_n     <= a_ctrl_reg.blank_n;
            b_reg.row_address <= a_ctrl_reg.row_address;
            b_reg.frame_end   <= a_ctrl_reg.frame_end;
        end
    end

    assign res_valid = b_valid_reg;
    assign res       = b_reg;

endmodule

FILE: dv/tb_led_matrix_scan_driver_unit.sv
// ---------------------------------------------------------------------------
// tb_led_matrix_scan_driver_unit
// Self-checking bench for the LED matrix scan driver. Pixel writes and scan
// ticks go in as random beats with random gaps and result stalls. A
// scoreboard tracks the pixel buffer and scan position and predicts the pin
// levels of every tick. The idle length is rewritten once the pipe has drained.
// ---------------------------------------------------------------------------
module tb_led_matrix_scan_driver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 50_000;

    class scan_scoreboard;
        logic [lmsd_pkg::COLOR_W-1:0]   pixels [lmsd_pkg::PLANES][lmsd_pkg::DOUBLE_ROWS]
                                               [lmsd_pkg::COLUMNS];
        lmsd_pkg::subframe_t            subframe;
        logic [lmsd_pkg::ROW_FLD_W-1:0] row;
        logic [lmsd_pkg::COL_FLD_W-1:0] col;
        logic [lmsd_pkg::PHASE_W-1:0]   phase;
        int unsigned                    idle_count;
        logic [lmsd_pkg::IDLE_W-1:0]    idle_ticks;
        lmsd_pkg::res_t                 pending_pins[$];
        int                             errors;

        function new();
            foreach (pixels[p, r, c])
                pixels[p][r][c] = '0;
            subframe    = lmsd_pkg::SF_PLANE0_A;
            row         = '0;
            col         = '0;
            phase       = lmsd_pkg::PH_CLK_HIGH;
            idle_count  = 0;
            idle_ticks  = lmsd_pkg::IDLE_TICKS_RESET;
            errors      = 0;
        endfunction

        // Store a pixel, or advance the scan by one tick and queue its pin levels
        function void apply_request(lmsd_pkg::req_t item);
            lmsd_pkg::res_t pins;
            logic           pl;
            if (item.kind == lmsd_pkg::KIND_PIXEL_WRITE)
            begin
                pixels[item.plane][item.double_row][item.column] = item.color;
                return;
            end
            pins         = '0;
            pins.blank_n = 1'b1;
            if (subframe == lmsd_pkg::SF_IDLE)
            begin
                idle_count++;
                if (idle_count >= 32'(idle_ticks))
                begin
                    idle_count = 0;
                    subframe   = lmsd_pkg::SF_PLANE0_A;
                    row        = '0;
                    col        = '0;
                    phase      = lmsd_pkg::PH_CLK_HIGH;
                end
            end
            else
            begin
                pl               = (subframe == lmsd_pkg::SF_PLANE1 && lmsd_pkg::PLANES > 1);
                pins.row_address = row;
                pins.color_pins  = pixels[pl][row][col];
                case (phase)
                    lmsd_pkg::PH_CLK_HIGH:   pins.shift_clock = 1'b1;
                    lmsd_pkg::PH_LATCH_HIGH: pins.latch_pin   = 1'b1;
                    lmsd_pkg::PH_ENABLE_ON:  pins.blank_n     = 1'b0;
                    default: ;
                endcase
                // column stays on the last one through the latch and enable phases
                if (phase == lmsd_pkg::PH_CLK_LOW && int'(col) != lmsd_pkg::COLUMNS - 1)
                begin
                    col   = col + 1'b1;
                    phase = lmsd_pkg::PH_CLK_HIGH;
                end
                else if (phase != lmsd_pkg::PH_ENABLE_OFF)
                begin
                    phase = phase + 1'b1;
                end
                else
                begin
                    phase = lmsd_pkg::PH_CLK_HIGH;
                    col   = '0;
                    if (int'(row) != lmsd_pkg::DOUBLE_ROWS - 1)
                    begin
                        row = row + 1'b1;
                    end
                    else
                    begin
                        row = '0;
                        case (subframe)
                            lmsd_pkg::SF_PLANE0_A: subframe = lmsd_pkg::SF_PLANE1;
                            lmsd_pkg::SF_PLANE1:   subframe = lmsd_pkg::SF_PLANE0_B;
                            default:
                            begin
                                pins.frame_end = 1'b1;
                                idle_count = 0;
                                subframe   = (idle_ticks == '0) ? lmsd_pkg::SF_PLANE0_A
                                                                : lmsd_pkg::SF_IDLE;
                            end
                        endcase
                    end
                end
            end
            pending_pins.push_back(pins);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_pins(lmsd_pkg::res_t got);
            lmsd_pkg::res_t want;
            if (pending_pins.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pin beat, expected none, actual %h", $time, got);
                return;
            end
            want = pending_pins.pop_front();
            compare_field("color_pins",  32'(want.color_pins),  32'(got.color_pins));
            compare_field("shift_clock", 32'(want.shift_clock), 32'(got.shift_clock));
            compare_field("latch_pin",   32'(want.latch_pin),   32'(got.latch_pin));
            compare_field("blank_n",     32'(want.blank_n),     32'(got.blank_n));
            compare_field("row_address", 32'(want.row_address), 32'(got.row_address));
            compare_field("frame_end",   32'(want.frame_end),   32'(got.frame_end));
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_stall;
    lmsd_pkg::req_t              req;
    logic                        res_valid;
    logic                        res_stall;
    lmsd_pkg::res_t              res;
    logic                        cfg_write_enable;
    logic [lmsd_pkg::IDLE_W-1:0] cfg_write_data;

    scan_scoreboard              sb = new();
    int                          cycle_count = 0;

    led_matrix_scan_driver_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req              (req),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .res              (res),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.apply_request(req);
            if (res_valid && !res_stall)
                sb.check_pins(res);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d pin beats outstanding", $time,
                     sb.pending_pins.size());
            $display("led_matrix_scan_driver_unit test failed");
            $finish;
        end
    end

    // Result side: insert random stalls between beats
    initial
    begin : result_sink
        int hold;
        hold      = 0;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                hold--;
            end
            else
            begin
                res_stall <= 1'b0;
                @(posedge clk);
                if (res_valid)
                    hold = int'($urandom_range(0, 4));
            end
        end
    end

    function automatic lmsd_pkg::req_t pixel_write(input logic plane, input int r,
                                                   input int c, input int color);
        lmsd_pkg::req_t item;
        item.kind       = lmsd_pkg::KIND_PIXEL_WRITE;
        item.plane      = plane;
        item.double_row = lmsd_pkg::ROW_FLD_W'(r);
        item.column     = lmsd_pkg::COL_FLD_W'(c);
        item.color      = lmsd_pkg::COLOR_W'(color);
        return item;
    endfunction

    function automatic lmsd_pkg::req_t random_request(input int write_pct);
        lmsd_pkg::req_t item;
        item.kind       = (int'($urandom_range(0, 99)) < write_pct)
                          ? lmsd_pkg::KIND_PIXEL_WRITE : lmsd_pkg::KIND_SCAN_TICK;
        item.plane      = 1'($urandom_range(0, 1));
        item.double_row = lmsd_pkg::ROW_FLD_W'($urandom_range(0, lmsd_pkg::DOUBLE_ROWS - 1));
        item.column     = lmsd_pkg::COL_FLD_W'($urandom_range(0, lmsd_pkg::COLUMNS - 1));
        item.color      = lmsd_pkg::COLOR_W'($urandom_range(0, (1 << lmsd_pkg::COLOR_W) - 1));
        return item;
    endfunction

    // Called and returns at a falling edge; valid stays high if no gap follows
    task automatic send_item(input lmsd_pkg::req_t item);
        int gap;
        gap = int'($urandom_range(0, 4));
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Hold off until every predicted beat is back and any write has settled
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (sb.pending_pins.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_idle_ticks(input logic [lmsd_pkg::IDLE_W-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        sb.idle_ticks     = value;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        lmsd_pkg::req_t item;
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req              = '0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: first tick on a cleared buffer, corner pixels, ticks with junk fields
        item      = '0;
        item.kind = lmsd_pkg::KIND_SCAN_TICK;
        send_item(item);
        send_item(pixel_write(1'b0, 0, 0, 63));
        send_item(pixel_write(1'b0, 0, 1, 42));
        send_item(pixel_write(1'b1, 0, 0, 21));
        send_item(pixel_write(1'b1, lmsd_pkg::DOUBLE_ROWS - 1, lmsd_pkg::COLUMNS - 1, 63));
        send_item(pixel_write(1'b0, lmsd_pkg::DOUBLE_ROWS - 1, lmsd_pkg::COLUMNS - 1, 36));
        send_item(pixel_write(1'b0, 0, lmsd_pkg::COLUMNS - 1, 9));
        send_item(pixel_write(1'b0, lmsd_pkg::DOUBLE_ROWS - 1, 0, 0));
        repeat (6) send_item('1);
        send_item(pixel_write(1'b0, 0, 2, 17));
        repeat (4) send_item('1);

        // Mixed writes and ticks at the reset idle length
        repeat (450) send_item(random_request(40));

        // Drain fully, change the idle length, carry on scanning
        wait_for_drain();
        write_idle_ticks(16'd100);
        repeat (80) send_item(random_request(40));

        wait_for_drain();
        if (sb.errors == 0 && sb.pending_pins.size() == 0)
            $display("led_matrix_scan_driver_unit test passed");
        else
            $display("led_matrix_scan_driver_unit test failed");
        $finish;
    end

endmodule
